### src/lzwe_pkg.sv
// Package for the LZW byte encoder: code and table sizes, hash constant,
// and the layout of one dictionary table entry. No dependencies.
package lzwe_pkg;

  localparam int CODE_BITS  = 16;
  localparam int SLOT_BITS  = 17;
  localparam int HASH_SLOTS = 1 << SLOT_BITS;
  localparam int KEY_W      = CODE_BITS + 8;
  localparam int EPOCH_W    = 8;
  localparam int HASH_SHIFT = 7;
  localparam int PROD_W     = HASH_SHIFT + SLOT_BITS;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam logic [CODE_BITS-1:0] CODE_LIMIT = {CODE_BITS{1'b1}};
  localparam logic [CODE_BITS-1:0] FIRST_FREE = CODE_BITS'(256);
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

  typedef struct packed {
    logic [EPOCH_W-1:0]   epoch;
    logic [KEY_W-1:0]     key;
    logic [CODE_BITS-1:0] code;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### src/lzwe_in_if.sv
// Input channel of the LZW byte encoder: one raw byte per transaction.
// Depends on nothing.
interface lzwe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

### src/lzwe_out_if.sv
// Output channel of the LZW byte encoder: one code per transaction.
// Depends on lzwe_pkg.
interface lzwe_out_if;
  logic                          valid;
  logic                          ready;
  logic [lzwe_pkg::CODE_BITS-1:0] code_word;
  logic                          last_code;

  modport source (output valid, code_word, last_code, input ready);
  modport sink   (input valid, code_word, last_code, output ready);
endinterface

### src/lzw_byte_encoder.sv
// LZW byte encoder with fixed-width codes and a hashed dictionary table.
// Depends on lzwe_pkg, lzwe_in_if, lzwe_out_if and lzwe_ram.
//
// Usage: bytes arrive on in_i, one per transaction; last_byte marks the end
// of a stream. Codes leave on out_o; last_code marks the flushed final code.
// A byte that starts a stream only loads the prefix; any other byte is hashed,
// read from the table and compared, with one more read for every extra probe
// on a hash collision, plus an emit step for each code it emits. The core loop
// is the probe of the table RAM: hash, read, compare, then learn a new entry on a miss.
// Table entries carry an epoch tag; an entry counts as valid only if its tag
// matches the current epoch, so ending a stream just advances the epoch.
// After reset, and after every 255th stream when the epoch wraps, the block
// sweeps all 131072 table entries, one entry per cycle, with in_i.ready
// low. A finished code waits in an output register; while the receiver
// stalls, the block keeps working until it needs to emit the next code.
module lzw_byte_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzwe_in_if.sink     in_i,
  lzwe_out_if.source  out_o
);
  import lzwe_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_MISS  = 3'd4;
  localparam logic [2:0] ST_LAST  = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [CODE_BITS-1:0] prefix_q, prefix_d;
  logic                 pvalid_q, pvalid_d;
  logic [CODE_BITS-1:0] next_q, next_d;
  logic [EPOCH_W-1:0]   epoch_q, epoch_d;
  logic [SLOT_BITS-1:0] idx_q, idx_d;
  logic [SLOT_BITS:0]   probes_q, probes_d;
  logic                 store_q, store_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [7:0]           byte_q, byte_d;
  logic                 last_q, last_d;

  logic                 ovalid_q;
  logic [CODE_BITS-1:0] ocode_q;
  logic                 olast_q;

  logic                 push;
  logic                 push_last;
  logic                 slot_free;
  logic                 accept;
  logic [PROD_W-1:0]    prod;
  logic                 we, re;
  logic [SLOT_BITS-1:0] waddr, raddr;
  entry_t               wdata, rdata;

  lzwe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HASH_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign slot_free   = !ovalid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign prod        = PROD_W'(key_q) * HASH_MULT[PROD_W-1:0];

  always_comb begin
    state_d   = state_q;
    prefix_d  = prefix_q;
    pvalid_d  = pvalid_q;
    next_d    = next_q;
    epoch_d   = epoch_q;
    idx_d     = idx_q;
    probes_d  = probes_q;
    store_d   = store_q;
    key_d     = key_q;
    byte_d    = byte_q;
    last_d    = last_q;
    push      = 1'b0;
    push_last = 1'b0;
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = '{epoch: epoch_q, key: key_q, code: next_q};
    re        = 1'b0;
    raddr     = idx_q;

    unique case (state_q)
      ST_CLEAR: begin
        // Tag zero never matches a live epoch.
        we    = 1'b1;
        wdata = '0;
        idx_d = idx_q + 1'b1;
        if (idx_q == {SLOT_BITS{1'b1}}) begin
          epoch_d = EPOCH_FIRST;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          byte_d = in_i.data_byte;
          last_d = in_i.last_byte;
          if (!pvalid_q) begin
            prefix_d = CODE_BITS'(in_i.data_byte);
            pvalid_d = 1'b1;
            state_d  = in_i.last_byte ? ST_LAST : ST_IDLE;
          end else begin
            key_d   = {prefix_q, in_i.data_byte};
            state_d = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        idx_d    = prod[PROD_W-1:HASH_SHIFT];
        raddr    = prod[PROD_W-1:HASH_SHIFT];
        re       = 1'b1;
        probes_d = '0;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        if (rdata.epoch != epoch_q) begin
          store_d = 1'b1;
          state_d = ST_MISS;
        end else if (rdata.key == key_q) begin
          prefix_d = rdata.code;
          state_d  = last_q ? ST_LAST : ST_IDLE;
        end else if (probes_q == (SLOT_BITS+1)'(HASH_SLOTS - 1)) begin
          // Every slot was probed: the table is full.
          store_d = 1'b0;
          state_d = ST_MISS;
        end else begin
          probes_d = probes_q + 1'b1;
          idx_d    = idx_q + 1'b1;
          raddr    = idx_q + 1'b1;
          re       = 1'b1;
        end
      end
      ST_MISS: begin
        if (slot_free) begin
          push = 1'b1;
          if (next_q < CODE_LIMIT) begin
            we     = store_q;
            next_d = next_q + 1'b1;
          end
          prefix_d = CODE_BITS'(byte_q);
          state_d  = last_q ? ST_LAST : ST_IDLE;
        end
      end
      ST_LAST: begin
        if (slot_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          prefix_d  = '0;
          pvalid_d  = 1'b0;
          next_d    = FIRST_FREE;
          if (epoch_q == EPOCH_LAST) begin
            idx_d   = '0;
            state_d = ST_CLEAR;
          end else begin
            epoch_d = epoch_q + 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      prefix_q <= '0;
      pvalid_q <= 1'b0;
      next_q   <= FIRST_FREE;
      epoch_q  <= EPOCH_FIRST;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      prefix_q <= prefix_d;
      pvalid_q <= pvalid_d;
      next_q   <= next_d;
      epoch_q  <= epoch_d;
      idx_q    <= idx_d;
      if (push) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    probes_q <= probes_d;
    store_q  <= store_d;
    key_q    <= key_d;
    byte_q   <= byte_d;
    last_q   <= last_d;
    if (push) begin
      ocode_q <= prefix_q;
      olast_q <= push_last;
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.code_word = ocode_q;
  assign out_o.last_code = olast_q;

endmodule

### src/lzwe_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module lzwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### sim/lzwe_tb_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the LZW byte encoder testbench: a dictionary model that
// predicts codes per input byte and checks each emitted code. Uses lzwe_pkg.
package lzwe_tb_scoreboard_pkg;
  import lzwe_pkg::*;

  typedef struct packed {
    logic [CODE_BITS-1:0] code_word;
    logic                 last_code;
  } code_item_t;

  class lzw_scoreboard;
    logic [CODE_BITS-1:0] cur_prefix;
    bit                   have_prefix;
    int unsigned          free_code;
    // The dictionary is keyed directly by (prefix, byte); a real hash only
    // changes where entries live, never which codes come out.
    logic [CODE_BITS-1:0] dict[int unsigned];
    code_item_t           pending_codes[$];
    int                   mismatches;

    function new();
      mismatches = 0;
      restart_stream();
    endfunction

    function void restart_stream();
      cur_prefix  = '0;
      have_prefix = 0;
      free_code   = 256;
      dict.delete();
    endfunction

    function void note_byte(logic [7:0] data_byte, logic last_byte);
      int unsigned key;
      code_item_t  c;
      if (!have_prefix) begin
        cur_prefix  = CODE_BITS'(data_byte);
        have_prefix = 1;
      end else begin
        key = 32'({cur_prefix, data_byte});
        if (dict.exists(key)) begin
          cur_prefix = dict[key];
        end else begin
          c.code_word = cur_prefix;
          c.last_code = 1'b0;
          pending_codes = {pending_codes, c};
          if (free_code < int'(CODE_LIMIT)) begin
            dict[key] = CODE_BITS'(free_code);
            free_code++;
          end
          cur_prefix = CODE_BITS'(data_byte);
        end
      end
      if (last_byte) begin
        c.code_word = cur_prefix;
        c.last_code = 1'b1;
        pending_codes = {pending_codes, c};
        restart_stream();
      end
    endfunction

    function void check_code(logic [CODE_BITS-1:0] code_word, logic last_code);
      code_item_t exp_c;
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected code %0d last=%0b with nothing pending", code_word, last_code);
        return;
      end
      exp_c = pending_codes.pop_front();
      if (code_word !== exp_c.code_word || last_code !== exp_c.last_code) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Code mismatch: expected %0d last=%0b, got %0d last=%0b",
                   exp_c.code_word, exp_c.last_code, code_word, last_code);
      end
    endfunction
  endclass
endpackage

### sim/tb_lzw_byte_encoder.sv
`timescale 1ns / 100ps
// Top-level testbench for lzw_byte_encoder: drives byte streams with random
// gaps and stalls and checks codes via lzwe_tb_scoreboard_pkg.
module tb_lzw_byte_encoder;
  import lzwe_pkg::*;
  import lzwe_tb_scoreboard_pkg::*;

  localparam int MAX_CYCLES = 3_000_000;

  logic clk_i;
  logic rst_ni;
  longint unsigned cycle_cnt;
  lzw_scoreboard sb;

  lzwe_in_if  in_if ();
  lzwe_out_if out_if ();

  lzw_byte_encoder u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Send one byte and wait for its transaction, with a random gap first.
  // The valid line stays high after the transaction until the next call.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_byte(b, last);
    @(negedge clk_i);
  endtask

  // Drop valid after the last byte of a burst.
  task automatic stop_input();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_stream(input int len, input int alpha);
    int i;
    for (i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, alpha - 1)), i == len - 1);
  endtask

  // Receiver: random stall before each transaction.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_code(out_if.code_word, out_if.last_code);
    end
  end

  // Watchdog.
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > MAX_CYCLES) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int wait_cnt;
    sb = new();
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single-byte stream, byte extremes, repeats that hit the table.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    for (i = 0; i < 8; i++) send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    for (i = 0; i < 6; i++) send_byte(i[0] ? 8'h0F : 8'hF0, i == 5);
    stop_input();

    // Hold off until the pipeline is drained.
    while (sb.pending_codes.size() != 0) @(negedge clk_i);

    // Random streams: mostly short, low-alphabet to exercise learned entries.
    i = 0;
    while (i < 600) begin
      automatic int len   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                        : $urandom_range(1, 12);
      automatic int alpha = ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(1, 4);
      send_stream(len, alpha);
      i += len;
    end
    stop_input();

    wait_cnt = 0;
    while (sb.pending_codes.size() != 0 && wait_cnt < 100000) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (50) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending_codes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
